@@ hdl/pds_pkg.sv @@
// Shared types and constants for the PLL divider search block.
// Used by pds_serial_div, pds_shift_pick and pll_divider_search.
// No dependencies.
`default_nettype none

package pds_pkg;

    // Field widths
    localparam int FREQ_W  = 32;
    localparam int PRE_W   = 3;
    localparam int MUL_W   = 5;
    localparam int SHIFT_W = 3;
    localparam int K_W     = 6;   // multiplier factor, code plus offset
    localparam int OSC_W   = FREQ_W + K_W;
    localparam int REM_W   = 3;   // remainder of a division by at most five

    // Search limits
    localparam logic [PRE_W-1:0]   PRE_MAX     = 3'd4;
    localparam logic [K_W-1:0]     MULT_OFFSET = 6'd4;
    localparam logic [MUL_W-1:0]   MULT_MAX    = 5'd31;
    localparam logic [K_W-1:0]     K_LAST      = MULT_OFFSET + {1'b0, MULT_MAX};
    localparam int                 SHIFT_COUNT = 7;
    localparam logic [FREQ_W-1:0]  REF_MIN_HZ  = 32'd4000000;
    localparam logic [OSC_W-1:0]   OSC_MIN_HZ  = 38'd48000000;

    // Stream word layouts
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // Quotient and remainder of the reference over the predivider
    typedef struct packed {
        logic [FREQ_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } div_res_t;

    // One candidate combination
    typedef struct packed {
        logic               valid;
        logic [PRE_W-1:0]   pre;
        logic [MUL_W-1:0]   mul;
        logic [SHIFT_W-1:0] shift;
        logic [FREQ_W-1:0]  hz;
    } cand_t;

endpackage

`default_nettype wire

@@ hdl/pds_serial_div.sv @@
// Bit-serial restoring divider of a 32-bit reference by a small divisor (1 to 5).
// One quotient bit per cycle; depends on pds_pkg.
`default_nettype none

module pds_serial_div
    import pds_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [FREQ_W-1:0] dividend,
    input  wire logic [REM_W-1:0]  divisor,
    output logic                   done,
    output div_res_t               result
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [4:0]            cnt_reg;
    logic [FREQ_W-1:0]     quot_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      div_reg;
    logic [REM_W:0]        trial;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial = {rem_reg, quot_reg[FREQ_W-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits from the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[FREQ_W-2:0], fits};
            rem_reg  <= fits ? REM_W'(trial - {1'b0, div_reg}) : REM_W'(trial);
        end
    end

    assign done        = done_reg;
    assign result.quot = quot_reg;
    assign result.rem  = rem_reg;

endmodule

`default_nettype wire

@@ hdl/pds_shift_pick.sv @@
// Compares all seven output shifts of one oscillator value against the request
// and registers the best candidate; depends on pds_pkg.
`default_nettype none

module pds_shift_pick
    import pds_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic [OSC_W-1:0]   osc,
    input  wire logic [FREQ_W-1:0]  req,
    input  wire logic [PRE_W-1:0]   pre,
    input  wire logic [MUL_W-1:0]   mul,
    output cand_t                   cand
);

    cand_t lane [SHIFT_COUNT];
    cand_t lvl1 [4];
    cand_t lvl2 [2];
    cand_t best;
    cand_t cand_reg;
    logic  osc_ok;

    // Keep the left operand on a tie, so the smaller shift wins.
    function automatic cand_t better(input cand_t a, input cand_t b);
        cand_t r;
        r = (b.hz > a.hz) ? b : a;
        return r;
    endfunction

    assign osc_ok = in_valid && (osc >= OSC_MIN_HZ);

    // One lane per shift; a lane over the request counts as zero.
    always_comb begin
        for (int s = 0; s < SHIFT_COUNT; s++) begin
            lane[s].valid = osc_ok;
            lane[s].pre   = pre;
            lane[s].mul   = mul;
            lane[s].shift = SHIFT_W'(s);
            lane[s].hz    = osc[s +: FREQ_W];
            if (lane[s].hz > req) begin
                lane[s].hz = '0;
            end
        end
    end

    // Maximum tree over the lanes.
    always_comb begin
        lvl1[0] = better(lane[0], lane[1]);
        lvl1[1] = better(lane[2], lane[3]);
        lvl1[2] = better(lane[4], lane[5]);
        lvl1[3] = lane[6];
        lvl2[0] = better(lvl1[0], lvl1[1]);
        lvl2[1] = better(lvl1[2], lvl1[3]);
        best    = better(lvl2[0], lvl2[1]);
    end

    // Candidate register; only the valid flag needs a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.valid <= 1'b0;
        end else begin
            cand_reg.valid <= best.valid;
        end
        cand_reg.pre   <= best.pre;
        cand_reg.mul   <= best.mul;
        cand_reg.shift <= best.shift;
        cand_reg.hz    <= best.hz;
    end

    assign cand = cand_reg;

endmodule

`default_nettype wire

@@ hdl/pll_divider_search.sv @@
// PLL divider search: for a reference and a requested frequency, finds the
// predivider, multiplier and output shift that give the highest output not
// above the request.
//
// The slave channel takes one word: reference_hz in tdata[31:0], requested_hz
// in tdata[63:32]. The master channel returns one word per input word with
// the chosen codes, the achieved frequency and a found flag.
// s_tready is high only while the search sequencer is idle. Each predivider
// takes a load state and a serial division of the reference (the divider
// unit), then, when the quotient reaches 4 MHz, a sweep in which one shared
// adder steps the oscillator value through the multipliers, one per cycle,
// while all seven shifts are compared at once, and a state to move on (the
// drain state and then the next state after a sweep). m_tvalid rises once
// every predivider is done and the output register is free, and the next word
// can be taken from that cycle on; one word is handled at a time.
// The result sits in an output register: the next input word is accepted
// while it waits; a new result is held back until the receiver takes the old.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle.
`default_nettype none

module pll_divider_search
    import pds_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] reference_hz, [63:32] requested_hz
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [2:0] prediv_code, [7:3] mult_code, [10:8] shift_code,
    // [42:11] achieved_hz, [43] found, [47:44] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_STEP,
        ST_DRAIN,
        ST_NEXT,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [FREQ_W-1:0]   ref_reg;
    logic [FREQ_W-1:0]   req_reg;
    logic [PRE_W-1:0]    pre_reg;
    logic [FREQ_W-1:0]   qr_reg;
    logic [REM_W-1:0]    rr_reg;
    logic [OSC_W-1:0]    q_reg;
    logic [REM_W-1:0]    r_reg;
    logic [K_W-1:0]      k_reg;
    cand_t               best_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                s_fire;
    logic                div_done;
    div_res_t            div_res;
    logic [REM_W-1:0]    divisor;
    logic [REM_W:0]      r_sum;
    logic                carry;
    logic [REM_W-1:0]    r_next;
    logic [OSC_W-1:0]    q_next;
    logic                pick_valid;
    logic [MUL_W-1:0]    mul_wide;
    cand_t               cand;
    logic                out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign divisor  = REM_W'(pre_reg + 3'd1);
    assign out_free = !m_tvalid_reg || m_tready;

    pds_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_LOAD),
        .dividend (ref_reg),
        .divisor  (divisor),
        .done     (div_done),
        .result   (div_res)
    );

    // Shared adder: q and r track floor and remainder of ref * k / divisor.
    always_comb begin
        r_sum  = {1'b0, r_reg} + {1'b0, rr_reg};
        carry  = r_sum >= {1'b0, divisor};
        r_next = carry ? REM_W'(r_sum - {1'b0, divisor}) : REM_W'(r_sum);
        q_next = q_reg + {{(OSC_W-FREQ_W){1'b0}}, qr_reg} + {{(OSC_W-1){1'b0}}, carry};
    end

    // Values from the multiplier offset upward are real multiplier codes.
    assign pick_valid = (state_reg == ST_STEP) && (k_reg >= MULT_OFFSET);
    assign mul_wide   = MUL_W'(k_reg - MULT_OFFSET);

    pds_shift_pick u_pick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pick_valid),
        .osc      (q_reg),
        .req      (req_reg),
        .pre      (pre_reg),
        .mul      (mul_wide),
        .cand     (cand)
    );

    // Sequencer, best-so-far and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            best_reg.valid <= 1'b0;
        end else begin
            // The finish state reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            // A strictly larger output replaces the best so far.
            if (cand.valid && (cand.hz > best_reg.hz)) begin
                best_reg <= cand;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        ref_reg        <= s_tdata[FREQ_W-1:0];
                        req_reg        <= s_tdata[2*FREQ_W-1:FREQ_W];
                        pre_reg        <= '0;
                        best_reg       <= '0;
                        state_reg      <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        qr_reg <= div_res.quot;
                        rr_reg <= div_res.rem;
                        q_reg  <= '0;
                        r_reg  <= '0;
                        k_reg  <= '0;
                        state_reg <= (div_res.quot < REF_MIN_HZ) ? ST_NEXT : ST_STEP;
                    end
                end
                ST_STEP: begin
                    q_reg <= q_next;
                    r_reg <= r_next;
                    k_reg <= k_reg + 6'd1;
                    if (k_reg == K_LAST) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (pre_reg == PRE_MAX) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        pre_reg   <= pre_reg + 3'd1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'b0, best_reg.valid, best_reg.hz, best_reg.shift,
                                         best_reg.mul, best_reg.pre};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The best so far never exceeds the request and is nonzero once found.
    a_best_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && best_reg.valid) |->
            (best_reg.hz <= req_reg && best_reg.hz != '0))
        else $error("best candidate out of range");

    // A candidate only leaves the shift picker in the cycle after a step cycle.
    a_cand_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cand.valid |-> $past(state_reg == ST_STEP))
        else $error("candidate outside a multiplier sweep");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    // A result without a found combination carries all-zero fields.
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[43]) |-> (m_tdata[42:0] == '0))
        else $error("empty result with nonzero fields");

    // The predivider code stays within its range.
    a_pre_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> pre_reg <= PRE_MAX)
        else $error("predivider code out of range");

endmodule

`default_nettype wire

@@ tb/sv/pll_divider_search_tb.sv @@
// Self-checking testbench for pll_divider_search: drives reference/request words
// on the input stream, predicts each divider choice and checks every result word.
// Depends on pds_pkg and pll_divider_search from the hdl folder.
`timescale 1ns / 100ps

module pll_divider_search_tb;
    import pds_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_PCT     = 29;
    localparam int STALL_LIMIT  = 10000;
    localparam int DRAIN_CYCLES = 400;
    localparam int TUNED_ITEMS  = 1150;
    localparam int NOISE_ITEMS  = 300;

    // Expected divider choice for one request.
    typedef struct packed {
        logic [PRE_W-1:0]   pre;
        logic [MUL_W-1:0]   mul;
        logic [SHIFT_W-1:0] shift;
        logic [FREQ_W-1:0]  hz;
        logic               found;
    } clk_choice_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // [31:0] reference_hz, [63:32] requested_hz
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // [2:0] prediv_code, [7:3] mult_code, [10:8] shift_code,
    // [42:11] achieved_hz, [43] found, [47:44] zero
    logic [M_DATA_W-1:0] m_tdata;

    clk_choice_t pending_choices[$];
    clk_choice_t got_choice;
    clk_choice_t want_choice;

    int  errors;
    int  requests_sent;
    int  results_checked;
    int  found_count;
    int  none_count;
    int  stall_cycles;
    bit  steady;

    pll_divider_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Exhaustive search over predivider, multiplier and shift, keeping the first best.
    function automatic clk_choice_t search_dividers(input logic [31:0] ref_hz,
                                                    input logic [31:0] req_hz);
        clk_choice_t best;
        bit [63:0]   divisor;
        bit [63:0]   osc_hz;
        bit [31:0]   out_hz;
        best = '0;
        for (int p = 0; p <= int'(PRE_MAX); p++) begin
            divisor = 64'(p + 1);
            if ((64'(ref_hz) / divisor) >= 64'(REF_MIN_HZ)) begin
                for (int m = 0; m <= int'(MULT_MAX); m++) begin
                    osc_hz = 64'(ref_hz) * 64'(m + int'(MULT_OFFSET)) / divisor;
                    if (osc_hz >= 64'(OSC_MIN_HZ)) begin
                        for (int s = 0; s < SHIFT_COUNT; s++) begin
                            // Only the low 32 bits of the shifted value count.
                            out_hz = 32'(osc_hz >> s);
                            if (out_hz <= req_hz && out_hz > best.hz) begin
                                best.pre   = PRE_W'(p);
                                best.mul   = MUL_W'(m);
                                best.shift = SHIFT_W'(s);
                                best.hz    = out_hz;
                                best.found = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    // Output of one chosen combination, used to aim requests at reachable values.
    function automatic logic [31:0] reachable_hz(input logic [31:0] ref_hz,
                                                 input int p, input int m, input int s);
        bit [63:0] osc_hz;
        osc_hz = 64'(ref_hz) * 64'(m + int'(MULT_OFFSET)) / 64'(p + 1);
        return 32'(osc_hz >> s);
    endfunction

    // Send one request word, with random idle cycles ahead of it.
    task automatic send_request(input logic [31:0] ref_hz, input logic [31:0] req_hz);
        clk_choice_t want;
        want = search_dividers(ref_hz, req_hz);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {req_hz, ref_hz};
        do @(posedge aclk); while (!s_tready);
        pending_choices.push_back(want);
        requests_sent++;
        if (want.found)
            found_count++;
        else
            none_count++;
    endtask

    task automatic end_stimulus();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Cases where no combination qualifies, plus the exact thresholds.
    task automatic test_no_solution();
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd3_999_999, 32'hFFFF_FFFF);
        send_request(32'd4_000_000, 32'hFFFF_FFFF);
        send_request(32'd8_000_000, 32'd0);
        send_request(32'd8_000_000, 32'd1_000);
        send_request(32'd8_000_000, 32'd750_000);
        send_request(32'd8_000_000, 32'd749_999);
    endtask

    // Predivider boundaries where the divided reference sits right at 4 MHz.
    task automatic test_prediv_thresholds();
        send_request(32'd7_999_999, 32'd48_000_000);
        send_request(32'd8_000_000, 32'd48_000_000);
        send_request(32'd19_999_999, 32'd333_333_333);
        send_request(32'd20_000_000, 32'd333_333_333);
        send_request(32'd12_000_000, 32'd47_999_999);
    endtask

    // Equal outputs from different combinations: the first one must win.
    task automatic test_ties();
        send_request(32'd8_000_000, 32'd96_000_000);
        send_request(32'd12_000_000, 32'd48_000_000);
        send_request(32'd16_000_000, 32'd64_000_000);
        send_request(32'd10_000_000, 32'd140_000_000);
    endtask

    // Extreme field values, including oscillator values that overflow 32 bits.
    task automatic test_wide_values();
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'hFFFF_FFFF, 32'd100_000_000);
        send_request(32'h8000_0000, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'd12_345_678);
        send_request(32'd400_000_000, 32'h7FFF_FFFF);
        send_request(32'd40_000_000, 32'hFFFF_FFFF);
    endtask

    // Plausible references with requests aimed at or next to reachable outputs.
    task automatic test_tuned_requests(input int count);
        logic [31:0] ref_hz;
        logic [31:0] req_hz;
        int          pick;
        for (int i = 0; i < count; i++) begin
            // A long stretch without any idling on either side.
            steady = (i >= count / 2 && i < count / 2 + 300);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                ref_hz = $urandom_range(4_000_000, 50_000_000);
            else if (pick < 85)
                ref_hz = 32'($urandom_range(1, 5) * 4_000_000 + $urandom_range(0, 4) - 2);
            else
                ref_hz = $urandom_range(1_000_000, 500_000_000);
            pick = $urandom_range(0, 99);
            if (pick < 60)
                req_hz = reachable_hz(ref_hz, $urandom_range(0, 4), $urandom_range(0, 31),
                                      $urandom_range(0, 6)) + 32'($urandom_range(0, 2)) - 32'd1;
            else if (pick < 85)
                req_hz = $urandom_range(0, 400_000_000);
            else
                req_hz = $urandom;
            send_request(ref_hz, req_hz);
        end
        steady = 1'b0;
    endtask

    // Full-range random words so every input bit sees both values.
    task automatic test_random_noise(input int count);
        logic [31:0] ref_hz;
        logic [31:0] req_hz;
        for (int i = 0; i < count; i++) begin
            ref_hz = $urandom;
            req_hz = $urandom;
            if ($urandom_range(0, 9) == 0)
                ref_hz = ref_hz >> $urandom_range(0, 31);
            if ($urandom_range(0, 9) == 0)
                req_hz = req_hz >> $urandom_range(0, 31);
            send_request(ref_hz, req_hz);
        end
    endtask

    // Result checker: each accepted word against the oldest prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_choice.pre   = m_tdata[2:0];
            got_choice.mul   = m_tdata[7:3];
            got_choice.shift = m_tdata[10:8];
            got_choice.hz    = m_tdata[42:11];
            got_choice.found = m_tdata[43];
            if (pending_choices.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want_choice = pending_choices.pop_front();
                results_checked++;
                check_field("prediv_code", 32'(want_choice.pre), 32'(got_choice.pre));
                check_field("mult_code", 32'(want_choice.mul), 32'(got_choice.mul));
                check_field("shift_code", 32'(want_choice.shift), 32'(got_choice.shift));
                check_field("achieved_hz", want_choice.hz, got_choice.hz);
                check_field("found", 32'(want_choice.found), 32'(got_choice.found));
                check_field("padding", 32'd0, 32'(m_tdata[47:44]));
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("pll_divider_search_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        steady          = 1'b0;
        errors          = 0;
        requests_sent   = 0;
        results_checked = 0;
        found_count     = 0;
        none_count      = 0;
        stall_cycles    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_no_solution();
        test_prediv_thresholds();
        test_ties();
        test_wide_values();
        test_tuned_requests(TUNED_ITEMS);
        test_random_noise(NOISE_ITEMS);
        end_stimulus();

        // Drain outstanding results, then watch for stray words.
        while (pending_choices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results for %0d requests: %0d found a setting, %0d found none.",
                 results_checked, requests_sent, found_count, none_count);
        $display("Covered threshold and tie cases, 32-bit wrap, tuned and full-range requests.");
        if (errors == 0)
            $display("pll_divider_search_tb OK");
        else
            $display("pll_divider_search_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pds_pkg.sv
hdl/pds_serial_div.sv
hdl/pds_shift_pick.sv
hdl/pll_divider_search.sv
tb/sv/pll_divider_search_tb.sv
